// ===== src/gradient_optimizer_update_macros.svh =====
// Assertion macros for the optimiser update engine.
// Used by the port checker; no other dependencies.
`ifndef GRADIENT_OPTIMIZER_UPDATE_MACROS_SVH
`define GRADIENT_OPTIMIZER_UPDATE_MACROS_SVH

// Same-cycle implication.
`define GOU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("optimiser update check failed");

// Next-cycle implication.
`define GOU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("optimiser update check failed");

`endif

// ===== src/gou_pkg.sv =====
// Shared constants for the optimiser update engine.
// No dependencies; used by the interfaces, the top level and the checker.
package gou_pkg;

   localparam int ENTRIES_DEFAULT   = 1024;
   localparam int SUM_WIDTH_DEFAULT = 48;

   localparam int IDX_W      = 10;
   localparam int DATA_W     = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 24;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic MODE_SGD  = 1'b0;
   localparam logic MODE_ADAM = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_OPTIMIZER_MODE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARNING_RATE  = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_COEFF    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SECOND_COEFF   = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON        = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_RATE     = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EPOCH_NUMBER   = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_SIZE     = 4'd7;

   localparam logic        RST_OPTIMIZER_MODE = MODE_SGD;
   localparam logic [15:0] RST_LEARNING_RATE  = 16'd655;
   localparam logic [15:0] RST_FIRST_COEFF    = 16'd58982;
   localparam logic [23:0] RST_SECOND_COEFF   = 24'd16760438;
   localparam logic [15:0] RST_EPSILON        = 16'd1;
   localparam logic [23:0] RST_DECAY_RATE     = 24'd0;
   localparam logic [15:0] RST_EPOCH_NUMBER   = 16'd1;
   localparam logic [15:0] RST_BATCH_SIZE     = 16'd1;

endpackage

// ===== src/gou_if.sv =====
// Channel interfaces of the optimiser update engine: request, response, CSR write.
// Depends on gou_pkg.
interface gou_req_if import gou_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     func;
   logic [IDX_W-1:0]         entry_index;
   logic signed [DATA_W-1:0] load_value;
   logic signed [DATA_W-1:0] error_value;
   logic signed [DATA_W-1:0] activation_value;
   logic                     first_sample;
   logic                     last_sample;

   modport source (output valid, func, entry_index, load_value, error_value,
                   activation_value, first_sample, last_sample, input ready);
   modport sink   (input valid, func, entry_index, load_value, error_value,
                   activation_value, first_sample, last_sample, output ready);
endinterface

interface gou_rsp_if import gou_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [IDX_W-1:0]         updated_index;
   logic signed [DATA_W-1:0] updated_weight;
   logic                     saturated;

   modport source (output valid, updated_index, updated_weight, saturated, input ready);
   modport sink   (input valid, updated_index, updated_weight, saturated, output ready);
endinterface

interface gou_csr_if import gou_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  reg_index;
   logic [CSR_DATA_W-1:0] write_data;

   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

// ===== src/gradient_optimizer_update.sv =====
// Optimiser update engine (momentum SGD / Adam), Q16.16, top level.
// Depends on gou_pkg and the interfaces in gou_if.sv.
//
//  channel   dir  handshake      carries
//  req_ch    in   valid/ready    func, entry_index, load/error/activation, first/last
//  rsp_ch    out  valid/ready    updated_index, updated_weight, saturated
//  csr_ch    in   valid/ready    reg_index, write_data (ready always high)
//
// Loads write the tables directly. Samples stream at 1 per cycle (sum read-modify-write
// with forwarding) until a last sample, which holds req ready low for its update: SGD
// uses the 64-step shared divider once, Adam twice plus the 32-step root. After reset
// and any CSR write, step/correction derivation (divider, power loop) holds it low too.
// Response sits in an output register; a new update waits only for that slot.
module gradient_optimizer_update import gou_pkg::*; #(
   parameter int ENTRIES   = ENTRIES_DEFAULT,
   parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   gou_req_if.sink    req_ch,
   gou_rsp_if.source  rsp_ch,
   gou_csr_if.sink    csr_ch
);

   localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SW = SUM_WIDTH;
   localparam logic signed [65:0] SUM_MAX = (66'sd1 <<< (SW - 1)) - 66'sd1;
   localparam logic signed [65:0] SUM_MIN = -SUM_MAX - 66'sd1;

   typedef enum logic [4:0] {
      ST_DERIVE, ST_STEP, ST_POW, ST_POW_SQ, ST_CORR, ST_CORR_Q, ST_DIV,
      ST_IDLE, ST_ACC, ST_GRAD, ST_SGD_V, ST_ADAM_V1, ST_ADAM_V2, ST_ADAM_GSQ,
      ST_ADAM_S1, ST_ADAM_S2, ST_ADAM_VC, ST_ADAM_SC, ST_SQRT, ST_ADAM_DEN,
      ST_RATIO, ST_DELTA, ST_WRITE
   } state_type;

   // entry index modulo ENTRIES, by restoring subtraction
   function automatic logic [IDX_W-1:0] reduce_index(input logic [IDX_W-1:0] raw);
      logic [26:0] v;
      v = 27'(raw);
      for (int k = IDX_W - 1; k >= 0; k--) begin
         if (v >= (27'(ENTRIES) << k)) v = v - (27'(ENTRIES) << k);
      end
      return v[IDX_W-1:0];
   endfunction

   function automatic logic [32:0] sclip32(input logic signed [69:0] x);
      if (x > 70'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
      if (x < -70'sd2147483648) return {1'b1, 32'h8000_0000};
      return {1'b0, x[31:0]};
   endfunction

   function automatic logic [32:0] uclip32(input logic [69:0] x);
      if (x > 70'h0_FFFF_FFFF) return {1'b1, 32'hFFFF_FFFF};
      return {1'b0, x[31:0]};
   endfunction

   // magnitude quotient plus sign to a clipped signed word
   function automatic logic [32:0] qclip(input logic [63:0] q, input logic neg);
      if (!neg && q > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      if (neg && q > 64'h8000_0000) return {1'b1, 32'h8000_0000};
      return neg ? {1'b0, 32'h0 - q[31:0]} : {1'b0, q[31:0]};
   endfunction

   // ---------------- registers ----------------
   state_type state_ff, state_in, ret_ff, ret_in;

   logic        mode_ff, mode_in;
   logic [15:0] lr_ff, lr_in, b1_ff, b1_in, eps_ff, eps_in;
   logic [23:0] b2_ff, b2_in, decay_ff, decay_in;
   logic [15:0] epoch_ff, epoch_in, batch_ff, batch_in;

   logic [31:0] step_ff, step_in, c1_ff, c1_in, c2_ff, c2_in;
   logic        sel_ff, sel_in;
   logic [32:0] pow_r_ff, pow_r_in;
   logic [31:0] pow_base_ff, pow_base_in;
   logic [15:0] pow_e_ff, pow_e_in;

   logic [64:0] div_rem_ff, div_rem_in;
   logic [63:0] div_num_ff, div_num_in, div_den_ff, div_den_in;
   logic [5:0]  div_cnt_ff, div_cnt_in;

   logic [63:0] sq_x_ff, sq_x_in, sq_r_ff, sq_r_in, sq_bit_ff, sq_bit_in;

   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  first_ff, first_in, last_ff, last_in;
   logic signed [47:0]    prod_ff, prod_in;
   logic                  fwd_hit_ff, fwd_hit_in, fwd_clip_ff, fwd_clip_in;
   logic signed [SW-1:0]  fwd_sum_ff, fwd_sum_in;
   logic                  neg_ff, neg_in, sat_ff, sat_in;

   logic signed [31:0] w_ff, w_in, m1_ff, m1_in, g_ff, g_in, v_ff, v_in;
   logic signed [31:0] vc_ff, vc_in, dsrc_ff, dsrc_in, delta_ff, delta_in;
   logic [31:0]        m2_ff, m2_in, s_ff, s_in, gsq_ff, gsq_in;
   logic signed [67:0] acc_ff, acc_in;

   logic               rsp_valid_ff, rsp_valid_in, rsp_sat_ff, rsp_sat_in;
   logic [IDX_W-1:0]   rsp_idx_ff, rsp_idx_in;
   logic signed [31:0] rsp_w_ff, rsp_w_in;

   // ---------------- memories ----------------
   logic [31:0] w_mem  [ENTRIES];
   logic [31:0] m1_mem [ENTRIES];
   logic [31:0] m2_mem [ENTRIES];
   logic [SW:0] sum_mem [ENTRIES];   // clip flag on top of the sum

   logic [31:0] rd_w_ff, rd_m1_ff, rd_m2_ff;
   logic [SW:0] rd_sum_ff;

   logic [AW-1:0] rd_addr, wm_addr, sum_addr;
   logic          w_we, m1_we, m2_we, sum_we;
   logic [31:0]   w_wd, m1_wd, m2_wd;
   logic [SW:0]   sum_wd;

   always_ff @(posedge clock) begin
      if (w_we) w_mem[wm_addr] <= w_wd;
      if (m1_we) m1_mem[wm_addr] <= m1_wd;
      if (m2_we) m2_mem[wm_addr] <= m2_wd;
      if (sum_we) sum_mem[sum_addr] <= sum_wd;
      rd_w_ff   <= w_mem[rd_addr];
      rd_m1_ff  <= m1_mem[rd_addr];
      rd_m2_ff  <= m2_mem[rd_addr];
      rd_sum_ff <= sum_mem[rd_addr];
   end

   // ---------------- shared multiplier ----------------
   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_p;
   assign mul_p = mul_a * mul_b;

   logic req_take, csr_take, req_ready;
   logic [IDX_W-1:0] req_idx;

   assign req_ready = (state_ff == ST_IDLE) || (state_ff == ST_ACC && !last_ff);
   assign req_take  = req_ch.valid && req_ready;
   assign csr_take  = csr_ch.valid;
   assign req_idx   = reduce_index(req_ch.entry_index);
   assign rd_addr   = AW'(req_idx);

   assign req_ch.ready         = req_ready;
   assign csr_ch.ready         = 1'b1;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.updated_index = rsp_idx_ff;
   assign rsp_ch.updated_weight = rsp_w_ff;
   assign rsp_ch.saturated     = rsp_sat_ff;

   // ---------------- next state ----------------
   logic signed [SW-1:0] base_sum, new_sum;
   logic                 base_clip, new_clip;
   logic signed [65:0]   sum_t;
   logic signed [64:0]   sum_wide;
   logic [64:0]          div_sh;
   logic                 div_ge;
   logic [63:0]          sq_trial, den_t;
   logic [32:0]          clip_r, corr_den;
   logic [32:0]          vc_mag;

   always_comb begin
      state_in = state_ff; ret_in = ret_ff;
      mode_in = mode_ff; lr_in = lr_ff; b1_in = b1_ff; b2_in = b2_ff;
      eps_in = eps_ff; decay_in = decay_ff; epoch_in = epoch_ff; batch_in = batch_ff;
      step_in = step_ff; c1_in = c1_ff; c2_in = c2_ff; sel_in = sel_ff;
      pow_r_in = pow_r_ff; pow_base_in = pow_base_ff; pow_e_in = pow_e_ff;
      div_rem_in = div_rem_ff; div_num_in = div_num_ff; div_den_in = div_den_ff;
      div_cnt_in = div_cnt_ff;
      sq_x_in = sq_x_ff; sq_r_in = sq_r_ff; sq_bit_in = sq_bit_ff;
      idx_in = idx_ff; first_in = first_ff; last_in = last_ff; prod_in = prod_ff;
      fwd_hit_in = fwd_hit_ff; fwd_sum_in = fwd_sum_ff; fwd_clip_in = fwd_clip_ff;
      neg_in = neg_ff; sat_in = sat_ff;
      w_in = w_ff; m1_in = m1_ff; m2_in = m2_ff; g_in = g_ff; v_in = v_ff;
      s_in = s_ff; gsq_in = gsq_ff; vc_in = vc_ff; dsrc_in = dsrc_ff;
      delta_in = delta_ff; acc_in = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_idx_in = rsp_idx_ff; rsp_w_in = rsp_w_ff; rsp_sat_in = rsp_sat_ff;

      mul_a = '0; mul_b = '0;
      w_we = 1'b0; m1_we = 1'b0; m2_we = 1'b0; sum_we = 1'b0;
      w_wd = req_ch.load_value; m1_wd = '0; m2_wd = '0;
      wm_addr = AW'(req_idx); sum_addr = AW'(idx_ff); sum_wd = '0;

      base_sum  = first_ff ? '0 : (fwd_hit_ff ? fwd_sum_ff : rd_sum_ff[SW-1:0]);
      base_clip = first_ff ? 1'b0 : (fwd_hit_ff ? fwd_clip_ff : rd_sum_ff[SW]);
      sum_t = 66'(base_sum) + 66'(prod_ff);
      if (sum_t > SUM_MAX) begin
         new_sum = SUM_MAX[SW-1:0]; new_clip = 1'b1;
      end else if (sum_t < SUM_MIN) begin
         new_sum = SUM_MIN[SW-1:0]; new_clip = 1'b1;
      end else begin
         new_sum = sum_t[SW-1:0]; new_clip = base_clip;
      end
      sum_wide = 65'(new_sum);

      div_sh   = {div_rem_ff[63:0], div_num_ff[63]};
      div_ge   = div_sh >= {1'b0, div_den_ff};
      sq_trial = sq_r_ff + sq_bit_ff;
      den_t    = sq_r_ff + 64'(eps_ff);
      corr_den = 33'h1_0000_0000 - pow_r_ff;
      vc_mag   = vc_ff[31] ? 33'h0 - 33'(vc_ff) : 33'(vc_ff);
      clip_r   = '0;

      // new request taken, from IDLE or mid-stream in ACC
      if (req_take) begin
         if (req_ch.func == FUNC_LOAD) begin
            w_we = 1'b1; m1_we = 1'b1; m2_we = 1'b1;
         end else begin
            mul_a = 34'(req_ch.error_value);
            mul_b = 34'(req_ch.activation_value);
            prod_in  = 48'(mul_p >>> 16);
            idx_in   = req_idx;
            first_in = req_ch.first_sample;
            last_in  = req_ch.last_sample;
            fwd_hit_in = (state_ff == ST_ACC) && (req_idx == idx_ff);
         end
      end

      case (state_ff)
         ST_DERIVE: begin
            mul_a = 34'(decay_ff); mul_b = 34'(epoch_ff);
            div_num_in = {16'h0, lr_ff, 32'h0};
            div_den_in = 64'(mul_p[40:0]) + 64'h1_0000;
            div_rem_in = '0; div_cnt_in = '0;
            ret_in = ST_STEP; state_in = ST_DIV;
         end
         ST_DIV: begin
            div_rem_in = div_ge ? div_sh - {1'b0, div_den_ff} : div_sh;
            div_num_in = {div_num_ff[62:0], div_ge};
            div_cnt_in = div_cnt_ff + 6'd1;
            if (div_cnt_ff == 6'd63) state_in = ret_ff;
         end
         ST_STEP: begin
            step_in = div_num_ff[31:0];
            pow_r_in = 33'h1_0000_0000; pow_base_in = {b1_ff, 16'h0};
            pow_e_in = epoch_ff; sel_in = 1'b0; state_in = ST_POW;
         end
         ST_POW: begin
            mul_a = 34'(pow_r_ff); mul_b = 34'(pow_base_ff);
            if (pow_e_ff == '0) state_in = ST_CORR;
            else begin
               if (pow_e_ff[0]) pow_r_in = mul_p[64:32];
               state_in = ST_POW_SQ;
            end
         end
         ST_POW_SQ: begin
            mul_a = 34'(pow_base_ff); mul_b = 34'(pow_base_ff);
            pow_base_in = mul_p[63:32];
            pow_e_in = pow_e_ff >> 1;
            state_in = ST_POW;
         end
         ST_CORR: begin
            // power of one: correction pinned at full scale
            if (corr_den == '0) begin
               div_num_in = 64'hFFFF_FFFF; state_in = ST_CORR_Q;
            end else begin
               div_num_in = 64'h1_0000_0000_0000; div_den_in = 64'(corr_den);
               div_rem_in = '0; div_cnt_in = '0;
               ret_in = ST_CORR_Q; state_in = ST_DIV;
            end
         end
         ST_CORR_Q: begin
            clip_r = uclip32(70'(div_num_ff));
            if (!sel_ff) begin
               c1_in = clip_r[31:0];
               pow_r_in = 33'h1_0000_0000; pow_base_in = {b2_ff, 8'h0};
               pow_e_in = epoch_ff; sel_in = 1'b1; state_in = ST_POW;
            end else begin
               c2_in = clip_r[31:0]; state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_take && req_ch.func == FUNC_SAMPLE) state_in = ST_ACC;
         end
         ST_ACC: begin
            sum_we = 1'b1; sum_wd = {new_clip, new_sum};
            fwd_sum_in = new_sum; fwd_clip_in = new_clip;
            w_in = rd_w_ff; m1_in = rd_m1_ff; m2_in = rd_m2_ff;
            if (last_ff) begin
               sat_in = new_clip;
               neg_in = new_sum[SW-1];
               div_num_in = sum_wide[64] ? 64'(-sum_wide) : 64'(sum_wide);
               div_den_in = (batch_ff == '0) ? 64'd1 : 64'(batch_ff);
               div_rem_in = '0; div_cnt_in = '0;
               ret_in = ST_GRAD; state_in = ST_DIV;
            end else if (!(req_take && req_ch.func == FUNC_SAMPLE)) begin
               state_in = ST_IDLE;
            end
         end
         ST_GRAD: begin
            clip_r = qclip(div_num_ff, neg_ff);
            g_in = clip_r[31:0]; sat_in = sat_ff | clip_r[32];
            state_in = (mode_ff == MODE_ADAM) ? ST_ADAM_V1 : ST_SGD_V;
         end
         ST_SGD_V: begin
            mul_a = 34'(b1_ff); mul_b = 34'(m1_ff);
            clip_r = sclip32(70'(g_ff) + 70'(mul_p >>> 16));
            v_in = clip_r[31:0]; dsrc_in = clip_r[31:0];
            sat_in = sat_ff | clip_r[32]; state_in = ST_DELTA;
         end
         ST_ADAM_V1: begin
            mul_a = 34'(17'h1_0000 - 17'(b1_ff)); mul_b = 34'(g_ff);
            acc_in = mul_p; state_in = ST_ADAM_V2;
         end
         ST_ADAM_V2: begin
            mul_a = 34'(b1_ff); mul_b = 34'(m1_ff);
            clip_r = sclip32(70'((acc_ff + mul_p) >>> 16));
            v_in = clip_r[31:0]; sat_in = sat_ff | clip_r[32]; state_in = ST_ADAM_GSQ;
         end
         ST_ADAM_GSQ: begin
            mul_a = 34'(g_ff); mul_b = 34'(g_ff);
            clip_r = uclip32(70'($unsigned(mul_p) >> 16));
            gsq_in = clip_r[31:0]; sat_in = sat_ff | clip_r[32]; state_in = ST_ADAM_S1;
         end
         ST_ADAM_S1: begin
            mul_a = 34'(25'h100_0000 - 25'(b2_ff)); mul_b = 34'(gsq_ff);
            acc_in = mul_p; state_in = ST_ADAM_S2;
         end
         ST_ADAM_S2: begin
            mul_a = 34'(b2_ff); mul_b = 34'(m2_ff);
            clip_r = uclip32(70'($unsigned(acc_ff + mul_p) >> 24));
            s_in = clip_r[31:0]; sat_in = sat_ff | clip_r[32]; state_in = ST_ADAM_VC;
         end
         ST_ADAM_VC: begin
            mul_a = 34'(v_ff); mul_b = 34'(c1_ff);
            clip_r = sclip32(70'(mul_p >>> 16));
            vc_in = clip_r[31:0]; sat_in = sat_ff | clip_r[32]; state_in = ST_ADAM_SC;
         end
         ST_ADAM_SC: begin
            mul_a = 34'(s_ff); mul_b = 34'(c2_ff);
            sq_x_in = {mul_p[63:16], 16'h0};
            sq_r_in = '0; sq_bit_in = 64'h4000_0000_0000_0000;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            if (sq_bit_ff == '0) state_in = ST_ADAM_DEN;
            else begin
               if (sq_x_ff >= sq_trial) begin
                  sq_x_in = sq_x_ff - sq_trial;
                  sq_r_in = (sq_r_ff >> 1) + sq_bit_ff;
               end else begin
                  sq_r_in = sq_r_ff >> 1;
               end
               sq_bit_in = sq_bit_ff >> 2;
            end
         end
         ST_ADAM_DEN: begin
            // zero denominator stands in for the smallest step
            div_den_in = (den_t == '0) ? 64'd1 : den_t;
            div_num_in = {15'h0, vc_mag, 16'h0};
            neg_in = vc_ff[31];
            div_rem_in = '0; div_cnt_in = '0;
            ret_in = ST_RATIO; state_in = ST_DIV;
         end
         ST_RATIO: begin
            clip_r = qclip(div_num_ff, neg_ff);
            dsrc_in = clip_r[31:0]; sat_in = sat_ff | clip_r[32]; state_in = ST_DELTA;
         end
         ST_DELTA: begin
            mul_a = 34'(step_ff); mul_b = 34'(dsrc_ff);
            delta_in = 32'(mul_p >>> 32); state_in = ST_WRITE;
         end
         ST_WRITE: begin
            clip_r = sclip32(70'(w_ff) - 70'(delta_ff));
            if (!rsp_valid_ff || rsp_ch.ready) begin
               wm_addr = AW'(idx_ff);
               w_we = 1'b1; w_wd = clip_r[31:0];
               m1_we = 1'b1; m1_wd = v_ff;
               m2_we = (mode_ff == MODE_ADAM); m2_wd = s_ff;
               rsp_valid_in = 1'b1; rsp_idx_in = idx_ff;
               rsp_w_in = clip_r[31:0]; rsp_sat_in = sat_ff | clip_r[32];
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // register writes; any write re-derives the step and corrections
      if (csr_take) begin
         case (csr_ch.reg_index)
            CSR_OPTIMIZER_MODE: mode_in  = csr_ch.write_data[0];
            CSR_LEARNING_RATE:  lr_in    = csr_ch.write_data[15:0];
            CSR_FIRST_COEFF:    b1_in    = csr_ch.write_data[15:0];
            CSR_SECOND_COEFF:   b2_in    = csr_ch.write_data;
            CSR_EPSILON:        eps_in   = csr_ch.write_data[15:0];
            CSR_DECAY_RATE:     decay_in = csr_ch.write_data;
            CSR_EPOCH_NUMBER:   epoch_in = csr_ch.write_data[15:0];
            CSR_BATCH_SIZE:     batch_in = csr_ch.write_data[15:0];
            default: ;
         endcase
         state_in = ST_DERIVE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_DERIVE; ret_ff <= ST_IDLE;
         mode_ff <= RST_OPTIMIZER_MODE; lr_ff <= RST_LEARNING_RATE;
         b1_ff <= RST_FIRST_COEFF; b2_ff <= RST_SECOND_COEFF;
         eps_ff <= RST_EPSILON; decay_ff <= RST_DECAY_RATE;
         epoch_ff <= RST_EPOCH_NUMBER; batch_ff <= RST_BATCH_SIZE;
         sel_ff <= 1'b0; fwd_hit_ff <= 1'b0; rsp_valid_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in;
         mode_ff <= mode_in; lr_ff <= lr_in; b1_ff <= b1_in; b2_ff <= b2_in;
         eps_ff <= eps_in; decay_ff <= decay_in; epoch_ff <= epoch_in;
         batch_ff <= batch_in;
         sel_ff <= sel_in; fwd_hit_ff <= fwd_hit_in; rsp_valid_ff <= rsp_valid_in;
         div_cnt_ff <= div_cnt_in;
      end
      step_ff <= step_in; c1_ff <= c1_in; c2_ff <= c2_in;
      pow_r_ff <= pow_r_in; pow_base_ff <= pow_base_in; pow_e_ff <= pow_e_in;
      div_rem_ff <= div_rem_in; div_num_ff <= div_num_in; div_den_ff <= div_den_in;
      sq_x_ff <= sq_x_in; sq_r_ff <= sq_r_in; sq_bit_ff <= sq_bit_in;
      idx_ff <= idx_in; first_ff <= first_in; last_ff <= last_in; prod_ff <= prod_in;
      fwd_sum_ff <= fwd_sum_in; fwd_clip_ff <= fwd_clip_in;
      neg_ff <= neg_in; sat_ff <= sat_in;
      w_ff <= w_in; m1_ff <= m1_in; m2_ff <= m2_in; g_ff <= g_in; v_ff <= v_in;
      s_ff <= s_in; gsq_ff <= gsq_in; vc_ff <= vc_in; dsrc_ff <= dsrc_in;
      delta_ff <= delta_in; acc_ff <= acc_in;
      rsp_idx_ff <= rsp_idx_in; rsp_w_ff <= rsp_w_in; rsp_sat_ff <= rsp_sat_in;
   end

endmodule

// ===== src/gou_checker.sv =====
// Port-level checks for the optimiser update engine, bound to the top level.
// Depends on gou_pkg and gradient_optimizer_update_macros.svh.
`include "gradient_optimizer_update_macros.svh"

module gou_checker import gou_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              req_func,
   input logic              req_last,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [IDX_W-1:0]  rsp_index,
   input logic [DATA_W-1:0] rsp_weight,
   input logic              csr_valid,
   input logic              csr_ready
);

   // derivation runs straight after reset
   `GOU_ASSERT_IMPLIES(a_busy_after_reset, clock, 1'b0, $past(reset), !req_ready)
   // a register write restarts derivation
   `GOU_ASSERT_NEXT(a_busy_after_csr, clock, reset, csr_valid && csr_ready, !req_ready)
   // a last sample blocks further requests while the update runs
   `GOU_ASSERT_NEXT(a_busy_after_last, clock, reset, req_valid && req_ready && req_func == FUNC_SAMPLE && req_last, !req_ready)
   // a stalled response holds
   `GOU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_weight) && $stable(rsp_index))

endmodule

bind gradient_optimizer_update gou_checker u_gou_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_func   (req_ch.func),
   .req_last   (req_ch.last_sample),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .rsp_index  (rsp_ch.updated_index),
   .rsp_weight (rsp_ch.updated_weight),
   .csr_valid  (csr_ch.valid),
   .csr_ready  (csr_ch.ready)
);

// ===== tb/sv/gou_update_checker.sv =====
// Watches the request, response and CSR channels of the optimiser update engine,
// predicts each updated weight and compares it. Depends on gou_pkg and gou_if.sv.
module gou_update_checker import gou_pkg::*; (
   input  logic clock,
   input  logic reset,
   gou_req_if   req_ch,
   gou_rsp_if   rsp_ch,
   gou_csr_if   csr_ch,
   output int   fail_count,
   output int   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NENT = 1024;

   typedef struct {
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] weight;
      logic                     sat;
   } update_t;

   update_t weight_q[$];

   // shadow registers
   logic        mode;
   logic [15:0] lr, b1_reg, eps, epoch, batch;
   logic [23:0] b2_reg, decay;
   bit [63:0]   step, corr1, corr2;

   // shadow table
   longint    w_tab[NENT];
   longint    m1_tab[NENT];
   bit [63:0] m2_tab[NENT];
   longint    sum_tab[NENT];
   bit        sum_clip[NENT];

   function automatic longint clip32(longint v, inout bit f);
      if (v < -64'sd2147483648) begin
         f = 1;
         return -64'sd2147483648;
      end
      if (v > 64'sd2147483647) begin
         f = 1;
         return 64'sd2147483647;
      end
      return v;
   endfunction

   function automatic bit [63:0] uclip32(bit [63:0] v, inout bit f);
      if (v > 64'hFFFF_FFFF) begin
         f = 1;
         return 64'hFFFF_FFFF;
      end
      return v;
   endfunction

   // truncates toward zero, magnitude capped at 2^40
   function automatic longint quot_trunc(longint n, bit [63:0] d);
      bit [63:0] mag, q;
      mag = (n < 0) ? 64'(-n) : 64'(n);
      q = mag / d;
      if (q > (64'd1 << 40)) q = 64'd1 << 40;
      return (n < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic bit [63:0] root_floor(bit [63:0] x);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 1/(1-base^e), base and power in Q0.32, result Q16.16 clipped
   function automatic bit [63:0] bias_corr(bit [63:0] base, int unsigned e);
      bit [63:0] r, den, q;
      r = 64'd1 << 32;
      while (e != 0) begin
         if (e[0]) r = (r * base) >> 32;
         base = (base * base) >> 32;
         e = e >> 1;
      end
      den = (64'd1 << 32) - r;
      if (den == 0) return 64'hFFFF_FFFF;
      q = (64'd1 << 48) / den;
      return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
   endfunction

   function automatic void rederive();
      bit [63:0] den;
      den = (64'd1 << 16) + 64'(decay) * 64'(epoch);
      step = (64'(lr) << 32) / den;
      corr1 = bias_corr(64'(b1_reg) << 16, epoch);
      corr2 = bias_corr(64'(b2_reg) << 8, epoch);
   endfunction

   function automatic void apply_sample(int idx, longint err, longint act, bit first,
                                        bit last);
      longint smax, smin, prod, s, g, v, delta, w, b1, vc, ratio;
      bit [63:0] b2, gsq, s2, sc, den;
      bit f;
      update_t u;
      smax = (64'sd1 <<< 47) - 1;
      smin = -smax - 1;
      if (first) begin
         sum_tab[idx] = 0;
         sum_clip[idx] = 0;
      end
      prod = (err * act) >>> 16;
      s = sum_tab[idx];
      if (prod > 0 && s > smax - prod) begin
         s = smax;
         sum_clip[idx] = 1;
      end else if (prod < 0 && s < smin - prod) begin
         s = smin;
         sum_clip[idx] = 1;
      end else begin
         s = s + prod;
      end
      sum_tab[idx] = s;
      if (!last) return;

      f = sum_clip[idx];
      g = clip32(quot_trunc(s, (batch == 0) ? 64'd1 : 64'(batch)), f);
      if (mode == MODE_SGD) begin
         v = clip32(g + ((longint'(b1_reg) * m1_tab[idx]) >>> 16), f);
         m1_tab[idx] = v;
         delta = (longint'(step) * v) >>> 32;
      end else begin
         b1 = longint'(b1_reg);
         b2 = 64'(b2_reg);
         v = clip32(((65536 - b1) * g + b1 * m1_tab[idx]) >>> 16, f);
         gsq = uclip32(64'(g * g) >> 16, f);
         s2 = uclip32((((64'd1 << 24) - b2) * gsq + b2 * m2_tab[idx]) >> 24, f);
         m1_tab[idx] = v;
         m2_tab[idx] = s2;
         vc = clip32((v * longint'(corr1)) >>> 16, f);
         sc = (s2 * corr2) >> 16;
         den = root_floor(sc << 16) + 64'(eps);
         if (den == 0) den = 1;
         ratio = clip32(quot_trunc(vc * 65536, den), f);
         delta = (longint'(step) * ratio) >>> 32;
      end
      w = clip32(w_tab[idx] - delta, f);
      w_tab[idx] = w;
      u.idx = idx[IDX_W-1:0];
      u.weight = w[31:0];
      u.sat = f;
      weight_q.push_back(u);
   endfunction

   always @(posedge clock) begin
      update_t exp_u;
      if (reset) begin
         mode = RST_OPTIMIZER_MODE;
         lr = RST_LEARNING_RATE;
         b1_reg = RST_FIRST_COEFF;
         b2_reg = RST_SECOND_COEFF;
         eps = RST_EPSILON;
         decay = RST_DECAY_RATE;
         epoch = RST_EPOCH_NUMBER;
         batch = RST_BATCH_SIZE;
         rederive();
         weight_q.delete();
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (weight_q.size() == 0) begin
               $error("unexpected update: index %0d weight %0d", rsp_ch.updated_index,
                      rsp_ch.updated_weight);
               fail_count++;
            end else begin
               exp_u = weight_q.pop_front();
               if (rsp_ch.updated_index !== exp_u.idx) begin
                  $error("updated_index: expected %0d, got %0d", exp_u.idx,
                         rsp_ch.updated_index);
                  fail_count++;
               end
               if (rsp_ch.updated_weight !== exp_u.weight) begin
                  $error("updated_weight: expected %0d, got %0d", exp_u.weight,
                         rsp_ch.updated_weight);
                  fail_count++;
               end
               if (rsp_ch.saturated !== exp_u.sat) begin
                  $error("saturated: expected %0b, got %0b", exp_u.sat, rsp_ch.saturated);
                  fail_count++;
               end
            end
         end
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.reg_index)
               CSR_OPTIMIZER_MODE: mode = csr_ch.write_data[0];
               CSR_LEARNING_RATE:  lr = csr_ch.write_data[15:0];
               CSR_FIRST_COEFF:    b1_reg = csr_ch.write_data[15:0];
               CSR_SECOND_COEFF:   b2_reg = csr_ch.write_data[23:0];
               CSR_EPSILON:        eps = csr_ch.write_data[15:0];
               CSR_DECAY_RATE:     decay = csr_ch.write_data[23:0];
               CSR_EPOCH_NUMBER:   epoch = csr_ch.write_data[15:0];
               CSR_BATCH_SIZE:     batch = csr_ch.write_data[15:0];
               default: ;
            endcase
            rederive();
         end
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.func == FUNC_LOAD) begin
               w_tab[req_ch.entry_index] = longint'(req_ch.load_value);
               m1_tab[req_ch.entry_index] = 0;
               m2_tab[req_ch.entry_index] = 0;
            end else begin
               apply_sample(req_ch.entry_index, longint'(req_ch.error_value),
                            longint'(req_ch.activation_value), req_ch.first_sample,
                            req_ch.last_sample);
            end
         end
      end
      pending <= weight_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end

endmodule

// ===== tb/sv/tb_gradient_optimizer_update.sv =====
// Stimulus and verdict for the optimiser update engine: directed and random
// load/sample traffic across several CSR settings. Depends on gou_pkg, gou_if.sv
// and gou_update_checker.
module tb_gradient_optimizer_update import gou_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   logic clock;
   logic reset;
   int   fail_count, pending;

   gou_req_if req_ch ();
   gou_rsp_if rsp_ch ();
   gou_csr_if csr_ch ();

   gradient_optimizer_update uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch.sink),
      .rsp_ch (rsp_ch.source),
      .csr_ch (csr_ch.sink)
   );

   gou_update_checker chk (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_ch     (csr_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Entry bookkeeping: a sample only ever goes to a loaded entry, and a sample
   // without first_sample only to an entry whose sum has been started, so the
   // engine never reads a table slot that was never written.
   bit loaded [1024];
   bit started[1024];
   int loaded_q[$];
   int started_q[$];

   // sender burst state
   int burst_left;

   // long receiver hold-off: the top asks, the receiver process serves
   int hold_asked;
   int hold_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on run length; well above the slowest legal run.
   initial begin
      #8ms;
      $display("tb_gradient_optimizer_update: done, errors");
      $finish;
   end

   // Response side: stall pattern switches at random among always ready, coin toss and
   // mostly stalled, plus the long hold-off when asked.
   initial begin
      int hold_left, style, tick;
      hold_left = 0;
      style = 0;
      tick = 0;
      hold_done = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_done) begin
            hold_done++;
            hold_left = 600;
         end
         if (tick % 64 == 0) style = $urandom_range(0, 2);
         tick++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready = 1'b0;
         end else begin
            case (style)
               0:       rsp_ch.ready = 1'b1;
               1:       rsp_ch.ready = $urandom_range(0, 1);
               default: rsp_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // One request: driven at the falling edge, held until accepted. Between
   // bursts the sender leaves a random gap.
   task automatic send_req(logic func, int idx, logic [31:0] ld, logic [31:0] err,
                           logic [31:0] act, bit first, bit last);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_ch.valid = 1'b1;
      req_ch.func = func;
      req_ch.entry_index = idx[IDX_W-1:0];
      req_ch.load_value = ld;
      req_ch.error_value = err;
      req_ch.activation_value = act;
      req_ch.first_sample = first;
      req_ch.last_sample = last;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
      req_ch.valid = 1'b0;
      if (func == FUNC_LOAD) begin
         if (!loaded[idx]) loaded_q.push_back(idx);
         loaded[idx] = 1;
      end else if (!started[idx]) begin
         started[idx] = 1;
         started_q.push_back(idx);
      end
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] ri, logic [CSR_DATA_W-1:0] wd);
      csr_ch.valid = 1'b1;
      csr_ch.reg_index = ri;
      csr_ch.write_data = wd;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid = 1'b0;
   endtask

   // Engine must be idle: all updates back, then margin for a trailing
   // load or plain sample still in the pipe.
   task automatic settle();
      while (pending != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic set_config(logic m, logic [15:0] lr, logic [15:0] b1, logic [23:0] b2,
                             logic [15:0] ep, logic [23:0] dr, logic [15:0] en,
                             logic [15:0] bs);
      settle();
      csr_write(CSR_OPTIMIZER_MODE, 24'(m));
      csr_write(CSR_LEARNING_RATE, 24'(lr));
      csr_write(CSR_FIRST_COEFF, 24'(b1));
      csr_write(CSR_SECOND_COEFF, b2);
      csr_write(CSR_EPSILON, 24'(ep));
      csr_write(CSR_DECAY_RATE, dr);
      csr_write(CSR_EPOCH_NUMBER, 24'(en));
      csr_write(CSR_BATCH_SIZE, 24'(bs));
   endtask

   // Q16.16 operand: full range, small, unit-ish, or an extreme
   function automatic logic [31:0] rand_q16();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom();
         2:       return 32'($urandom_range(0, 32'h40000)) - 32'h20000;
         3:       return 32'($urandom_range(0, 32'h800000)) - 32'h400000;
         4:       return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000);
         default: return 32'($urandom_range(0, 32'h2000)) - 32'h1000;
      endcase
   endfunction

   // Random traffic, mostly whole batches on loaded entries with random
   // content; the rest is stray loads (first/last bits set too) and lone
   // accumulations into a running sum.
   task automatic random_traffic(int n_items, bit pause_midway);
      int done, idx, len, pick;
      logic [31:0] act;
      done = 0;
      while (done < n_items) begin
         if (pause_midway && done >= n_items / 2) begin
            pause_midway = 0;
            while (pending != 0) @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_req(FUNC_LOAD, $urandom_range(0, 1023), rand_q16(), $urandom(),
                     $urandom(), $urandom_range(0, 1), $urandom_range(0, 1));
            done++;
         end else if (pick < 14 && started_q.size() != 0) begin
            idx = started_q[$urandom_range(0, started_q.size() - 1)];
            if (loaded[idx]) begin
               send_req(FUNC_SAMPLE, idx, $urandom(), rand_q16(), rand_q16(), 1'b0, 1'b0);
               done++;
            end
         end else begin
            if (loaded_q.size() != 0 && $urandom_range(0, 9) < 7)
               idx = loaded_q[$urandom_range(0, loaded_q.size() - 1)];
            else
               idx = $urandom_range(0, 1023);
            if (!loaded[idx] || $urandom_range(0, 19) == 0) begin
               send_req(FUNC_LOAD, idx, rand_q16(), $urandom(), $urandom(), 1'b0, 1'b0);
               done++;
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 8) : $urandom_range(1, 4);
            for (int k = 0; k < len; k++) begin
               // a bias entry sends an activation of exactly one
               act = ($urandom_range(0, 4) == 0) ? 32'h0001_0000 : rand_q16();
               send_req(FUNC_SAMPLE, idx, $urandom(), rand_q16(), act, k == 0,
                        k == len - 1);
               done++;
            end
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      burst_left = 0;
      hold_asked = 0;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_LOAD;
      req_ch.entry_index = '0;
      req_ch.load_value = '0;
      req_ch.error_value = '0;
      req_ch.activation_value = '0;
      req_ch.first_sample = 1'b0;
      req_ch.last_sample = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.reg_index = '0;
      csr_ch.write_data = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      // --- directed, reset configuration (momentum SGD) ---
      send_req(FUNC_LOAD, 0, 32'h8000_0000, 0, 0, 1'b0, 1'b0);
      send_req(FUNC_LOAD, 1023, 32'h7FFF_FFFF, 0, 0, 1'b0, 1'b0);
      // load with first/last set: bits ignored, no update
      send_req(FUNC_LOAD, 341, 32'h5555_5555, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
      send_req(FUNC_LOAD, 682, 32'hAAAA_AAAA, 0, 0, 1'b0, 1'b0);
      send_req(FUNC_SAMPLE, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1);
      send_req(FUNC_SAMPLE, 1023, 0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b1);
      // bias entry: activation of one
      send_req(FUNC_SAMPLE, 341, 0, 32'h0003_8000, 32'h0001_0000, 1'b1, 1'b1);
      send_req(FUNC_SAMPLE, 682, 0, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1);
      // accumulator overflow: three maximal products exceed the sum range
      for (int k = 0; k < 3; k++)
         send_req(FUNC_SAMPLE, 341, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, k == 0, k == 2);
      for (int k = 0; k < 3; k++)
         send_req(FUNC_SAMPLE, 682, 0, 32'h8000_0000, 32'h7FFF_FFFF, k == 0, k == 2);
      // multi-sample batch on the same entry, then momentum builds on it
      for (int k = 0; k < 4; k++)
         send_req(FUNC_SAMPLE, 1023, 0, 32'hFFFF_0000 + k, 32'h0002_0000, k == 0, k == 3);
      send_req(FUNC_SAMPLE, 1023, 0, 0, 0, 1'b1, 1'b1);

      // --- phases across settings ---
      set_config(MODE_SGD, RST_LEARNING_RATE, RST_FIRST_COEFF, RST_SECOND_COEFF,
                 RST_EPSILON, RST_DECAY_RATE, RST_EPOCH_NUMBER, RST_BATCH_SIZE);
      random_traffic(90, 1'b0);

      set_config(MODE_ADAM, RST_LEARNING_RATE, RST_FIRST_COEFF, RST_SECOND_COEFF,
                 RST_EPSILON, RST_DECAY_RATE, RST_EPOCH_NUMBER, RST_BATCH_SIZE);
      hold_asked++; // receiver holds off long while requests keep coming
      random_traffic(100, 1'b0);

      // batch size zero is taken as one; out-of-list register indexes ignored
      set_config(MODE_SGD, 16'hFFFF, 16'hFFFF, 24'd0, 16'd0, 24'd0, 16'hFFFF, 16'd0);
      csr_write(4'd8, 24'hFFFFFF);
      csr_write(4'd15, 24'h000001);
      random_traffic(90, 1'b0);

      // epoch zero: corrections pinned at max; zero epsilon allows a zero root
      set_config(MODE_ADAM, 16'hFFFF, 16'd0, 24'd0, 16'd0, 24'hFFFFFF, 16'd0, 16'd1);
      random_traffic(90, 1'b0);

      set_config(MODE_ADAM, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF,
                 16'hFFFF, 16'hFFFF);
      random_traffic(90, 1'b1);

      set_config(MODE_SGD, 16'd0, 16'd0, 24'h123456, 16'd7, 24'hFFFFFF, 16'd1, 16'd3);
      random_traffic(80, 1'b0);

      set_config(MODE_ADAM, $urandom(), $urandom(), $urandom(), $urandom_range(0, 4096),
                 $urandom_range(0, 65536), $urandom_range(1, 40), $urandom_range(1, 6));
      random_traffic(120, 1'b0);

      set_config(MODE_SGD, $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom_range(0, 65536), $urandom_range(1, 40), $urandom_range(1, 6));
      random_traffic(120, 1'b0);

      // drain, then margin for the engine's longest update
      while (pending != 0) @(negedge clock);
      repeat (400) @(negedge clock);
      if (fail_count == 0) begin
         $display("tb_gradient_optimizer_update: done, clean");
      end else begin
         $display("tb_gradient_optimizer_update: done, errors");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/gou_pkg.sv
src/gou_if.sv
src/gradient_optimizer_update.sv
src/gou_checker.sv
tb/sv/gou_update_checker.sv
tb/sv/tb_gradient_optimizer_update.sv
